// ===== rtl/fspc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspc_pkg: shared types and constants for the step pulse command unit
// Widths of the payload fields, response codes and reset values.
// ----------------------------------------------------------------------------
package fspc_pkg;
	localparam int MOTOR_COUNT_DEF = 4;
	localparam int FRAME_BYTES = 6;
	localparam int MAX_RESULTS = 4;

	localparam logic [7:0] CODE_BAD_CHECK = 8'd255;
	localparam logic [7:0] CODE_BAD_CMD   = 8'd254;
	localparam logic [7:0] CODE_ACK       = 8'd253;
	localparam logic [7:0] CODE_END_BASE  = 8'd200;
	localparam logic [7:0] CODE_DIVIDER   = 8'd68;
	localparam logic [7:0] CODE_USTEP_WR  = 8'd60;
	localparam logic [7:0] CODE_USTEP_RD  = 8'd56;

	localparam logic [1:0] CFG_MIN_PULSE = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
	localparam logic [1:0] CFG_DIVIDER   = 2'd2;

	localparam logic [31:0] INTERVAL_RST = 32'd4000;
	localparam logic [15:0] MIN_PULSE_RST = 16'd3;
	localparam logic [23:0] TIMEOUT_RST = 24'd500000;

	// per-motor operations (code mod 14)
	typedef enum logic [3:0] {
		OP_RD_RUN, OP_WR_RUN, OP_RD_STEPS, OP_WR_STEPS, OP_RD_TARGET, OP_WR_TARGET,
		OP_RD_INTERVAL, OP_WR_INTERVAL, OP_RD_MODE, OP_WR_MODE, OP_RD_DIR, OP_WR_DIR,
		OP_RD_EN, OP_WR_EN
	} motor_op_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} event_t;

	typedef struct packed {
		logic        frame_valid;
		logic [7:0]  frame_code;
		logic [31:0] frame_data;
		logic [7:0]  frame_check;
		logic [3:0]  step_lines;
		logic [3:0]  dir_lines;
		logic [3:0]  enable_lines;
		logic        error_led;
		logic        last_of_run;
	} result_t;
endpackage

// ===== rtl/fspc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspc_if: valid/ready channel
// Carries a payload of type T with source and sink modports.
// ----------------------------------------------------------------------------
interface fspc_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/four_axis_step_pulse_command_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_axis_step_pulse_command_unit: step/dir/enable pulse command unit
// Frame decoding, per-motor pulse timing and response generation.
// ----------------------------------------------------------------------------
// Each event (a received byte or one microsecond tick) is processed in the
// cycle it is accepted; its results (one, or up to one end frame per motor)
// load a result queue and leave one per cycle while the sink is ready. A new
// event is taken in any cycle where the queue is empty or its last result is
// leaving, so the unit takes no event before all results of the last one
// have left. Configuration writes take effect on the next event.
module four_axis_step_pulse_command_unit
	import fspc_pkg::*;
#(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	fspc_if.sink        evt_in,
	fspc_if.source      res_out
);
	logic [15:0] min_pulse_q;
	logic [23:0] timeout_q;
	logic [7:0]  divider_q;

	logic [31:0] time_q, rx_last_q, tx_q;
	logic [7:0]  rx_q [5];
	logic [2:0]  rx_cnt_q;
	logic        led_q;
	logic [MOTOR_COUNT-1:0] run_q, pulse_q, dir_q, en_q;
	logic [31:0] steps_q [MOTOR_COUNT];
	logic [31:0] target_q [MOTOR_COUNT];
	logic [31:0] ival_q [MOTOR_COUNT];
	logic [7:0]  mode_q [MOTOR_COUNT];
	logic [31:0] edge_q [MOTOR_COUNT];

	logic [31:0] time_d, rx_last_d, tx_d;
	logic [2:0]  rx_cnt_d;
	logic        led_d;
	logic [MOTOR_COUNT-1:0] run_d, pulse_d, dir_d, en_d, end_m;
	logic [31:0] steps_d [MOTOR_COUNT];
	logic [31:0] target_d [MOTOR_COUNT];
	logic [31:0] ival_d [MOTOR_COUNT];
	logic [7:0]  mode_d [MOTOR_COUNT];
	logic [31:0] edge_d [MOTOR_COUNT];

	logic        take, push, can_push, have_frame, frame_ok;
	logic [7:0]  code, cmd_code, xsum;
	logic [31:0] data;
	logic [3:0]  mot;
	logic [3:0]  opn;
	result_t     res [MAX_RESULTS];
	logic [2:0]  res_cnt;
	logic [3:0]  stp_l, dir_l, en_l;

	assign evt_in.ready = can_push;
	assign take = evt_in.valid && can_push;
	assign push = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= MIN_PULSE_RST;
			timeout_q   <= TIMEOUT_RST;
			divider_q   <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_PULSE: min_pulse_q <= cfg_data[15:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_data;
				CFG_DIVIDER:   divider_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// split code into motor and operation by small subtract chain
	always_comb begin
		mot = 4'd0;
		opn = code[3:0];
		if (code >= 8'd42) begin
			mot = 4'd3; opn = 4'(code - 8'd42);
		end else if (code >= 8'd28) begin
			mot = 4'd2; opn = 4'(code - 8'd28);
		end else if (code >= 8'd14) begin
			mot = 4'd1; opn = 4'(code - 8'd14);
		end
	end

	always_comb begin
		time_d = time_q; rx_last_d = rx_last_q; tx_d = tx_q;
		rx_cnt_d = rx_cnt_q; led_d = led_q;
		run_d = run_q; pulse_d = pulse_q; dir_d = dir_q; en_d = en_q;
		steps_d = steps_q; target_d = target_q; ival_d = ival_q;
		mode_d = mode_q; edge_d = edge_q;
		end_m = '0;
		cmd_code = CODE_BAD_CMD;
		have_frame = 1'b0;
		frame_ok = 1'b0;
		code = rx_q[0];
		data = {evt_in.data.rx_byte, rx_q[3], rx_q[2], rx_q[1]};
		data = {rx_q[4], rx_q[3], rx_q[2], rx_q[1]};
		xsum = rx_q[0] ^ rx_q[1] ^ rx_q[2] ^ rx_q[3] ^ rx_q[4];
		if (evt_in.data.kind) begin
			time_d = time_q + 32'd1;
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				if (run_q[m]) begin
					if (steps_q[m] != 32'd0 && !pulse_q[m]) begin
						if (time_d - edge_q[m] >= ival_q[m]) begin
							pulse_d[m] = 1'b1;
							steps_d[m] = steps_q[m] - 32'(mode_q[m]);
							edge_d[m] = time_d;
						end
					end else if (pulse_q[m]) begin
						if (time_d - edge_q[m] >= 32'(min_pulse_q)) pulse_d[m] = 1'b0;
					end else begin
						run_d[m] = 1'b0;
						end_m[m] = 1'b1;
					end
				end
			end
			if (rx_cnt_q != 3'd0 && (time_d - rx_last_q) > 32'(timeout_q)) rx_cnt_d = 3'd0;
		end else begin
			rx_last_d = time_q;
			rx_cnt_d = rx_cnt_q + 3'd1;
			if (rx_cnt_q == 3'(FRAME_BYTES - 1)) begin
				rx_cnt_d = 3'd0;
				have_frame = 1'b1;
				frame_ok = xsum == evt_in.data.rx_byte;
			end
		end
		if (have_frame && !frame_ok) begin
			led_d = 1'b1;
			cmd_code = CODE_BAD_CHECK;
		end else if (have_frame) begin
			if (code > CODE_DIVIDER) begin
				cmd_code = CODE_BAD_CMD;
			end else if (code == CODE_DIVIDER) begin
				tx_d = 32'(divider_q); cmd_code = code;
			end else if (code >= CODE_USTEP_WR) begin
				if (32'((code - CODE_USTEP_WR) >> 1) < MOTOR_COUNT && !code[0]) begin
					tx_d[7:0] = 8'd0; cmd_code = code;
				end
			end else if (code >= CODE_USTEP_RD) begin
				if (32'(code - CODE_USTEP_RD) < MOTOR_COUNT) begin
					tx_d[7:0] = 8'd0; cmd_code = code;
				end
			end else if (32'(mot) < MOTOR_COUNT) begin
				cmd_code = CODE_ACK;
				for (int m = 0; m < MOTOR_COUNT; m++) begin
					if (mot == 4'(m)) begin
						case (motor_op_t'(opn))
							OP_RD_RUN: begin tx_d[7:0] = {7'd0, run_q[m]}; cmd_code = code; end
							OP_WR_RUN: begin
								if (run_q[m] != (rx_q[1] != 8'd0)) begin
									run_d[m] = rx_q[1] != 8'd0;
									if (rx_q[1] != 8'd0) begin
										pulse_d[m] = 1'b0;
										edge_d[m] = time_q - ival_q[m];
									end
								end
							end
							OP_RD_STEPS: begin tx_d = steps_q[m]; cmd_code = code; end
							OP_WR_STEPS: begin steps_d[m] = data; target_d[m] = data; end
							OP_RD_TARGET: begin tx_d = target_q[m]; cmd_code = code; end
							OP_WR_TARGET: target_d[m] = data;
							OP_RD_INTERVAL: begin tx_d = ival_q[m]; cmd_code = code; end
							OP_WR_INTERVAL: ival_d[m] = data;
							OP_RD_MODE: begin tx_d[7:0] = mode_q[m]; cmd_code = code; end
							OP_WR_MODE: mode_d[m] = rx_q[1];
							OP_RD_DIR: begin tx_d[7:0] = {7'd0, dir_q[m]}; cmd_code = code; end
							OP_WR_DIR: dir_d[m] = rx_q[1] != 8'd0;
							OP_RD_EN: begin tx_d[7:0] = {7'd0, !en_q[m]}; cmd_code = code; end
							OP_WR_EN: en_d[m] = rx_q[1] == 8'd0;
							default: ;
						endcase
					end
				end
			end
		end
	end

	// result assembly; line levels taken after the event
	always_comb begin
		logic [2:0] n;
		n = 3'd0;
		stp_l = '0; dir_l = '0; en_l = '0;
		stp_l[MOTOR_COUNT-1:0] = pulse_d;
		dir_l[MOTOR_COUNT-1:0] = dir_d;
		en_l[MOTOR_COUNT-1:0] = en_d;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			res[k] = '0;
			res[k].step_lines = stp_l;
			res[k].dir_lines = dir_l;
			res[k].enable_lines = en_l;
			res[k].error_led = led_d;
		end
		if (have_frame) begin
			res[0].frame_valid = 1'b1;
			res[0].frame_code = cmd_code;
			n = 3'd1;
		end else begin
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				if (end_m[m]) begin
					res[n[1:0]].frame_valid = 1'b1;
					res[n[1:0]].frame_code = CODE_END_BASE + 8'(m);
					n = n + 3'd1;
				end
			end
		end
		for (int k = 0; k < MAX_RESULTS; k++) begin
			res[k].frame_data = res[k].frame_valid ? tx_d : 32'd0;
			res[k].frame_check = res[k].frame_valid ?
				(res[k].frame_code ^ tx_d[7:0] ^ tx_d[15:8] ^ tx_d[23:16] ^ tx_d[31:24])
				: 8'd0;
		end
		if (n == 3'd0) n = 3'd1;
		res[n[1:0] - 2'd1].last_of_run = 1'b1;
		res_cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0; rx_last_q <= '0; tx_q <= '0; rx_cnt_q <= '0; led_q <= 1'b0;
			run_q <= '0; pulse_q <= '0; dir_q <= '1; en_q <= '0;
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				steps_q[m] <= '0; target_q[m] <= '0; ival_q[m] <= INTERVAL_RST;
				mode_q[m] <= 8'd1; edge_q[m] <= '0;
			end
		end else if (take) begin
			time_q <= time_d; rx_last_q <= rx_last_d; tx_q <= tx_d;
			rx_cnt_q <= rx_cnt_d; led_q <= led_d;
			run_q <= run_d; pulse_q <= pulse_d; dir_q <= dir_d; en_q <= en_d;
			steps_q <= steps_d; target_q <= target_d; ival_q <= ival_d;
			mode_q <= mode_d; edge_q <= edge_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !evt_in.data.kind && rx_cnt_q < 3'd5) rx_q[rx_cnt_q] <= evt_in.data.rx_byte;
	end

	fspc_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (res),
		.push_cnt (res_cnt),
		.can_push (can_push),
		.res_out  (res_out)
	);
endmodule

// ===== rtl/fspc_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspc_out_queue: result queue
// Holds the results of one event and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module fspc_out_queue
	import fspc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  result_t          push_res [MAX_RESULTS],
	input  logic [2:0]       push_cnt,
	output logic             can_push,
	fspc_if.source           res_out
);
	result_t    buf_q [MAX_RESULTS];
	logic [2:0] cnt_q;
	logic [1:0] idx_q;
	logic       pop;

	assign res_out.valid = cnt_q != 3'd0;
	assign res_out.data  = buf_q[idx_q];
	assign pop = res_out.valid && res_out.ready;
	// a new burst may load when empty or when the last one is leaving now
	assign can_push = (cnt_q == 3'd0) || (pop && cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (push) begin
			cnt_q <= push_cnt;
			idx_q <= 2'd0;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q <= push_res;
	end
endmodule

// ===== verif/four_axis_step_pulse_command_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_axis_step_pulse_command_unit_tb: self-checking bench for the step unit
// Drives received bytes and ticks with random gaps, predicts every response
// and line state in a behavioral motor/frame model, compares each result.
// ----------------------------------------------------------------------------
module four_axis_step_pulse_command_unit_tb;
	import fspc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_MIN_PULSE;
	logic [23:0] cfg_data = '0;

	fspc_if #(.T(event_t)) evt ();
	fspc_if #(.T(result_t)) res ();

	four_axis_step_pulse_command_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .evt_in(evt), .res_out(res)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// predictor state
	logic [15:0] p_min_pulse;
	logic [23:0] p_timeout;
	logic [7:0]  p_divider;
	logic [31:0] p_now;
	logic [7:0]  p_rx [FRAME_BYTES];
	int          p_rx_cnt;
	logic [31:0] p_rx_last;
	logic [31:0] p_tx;
	logic        p_led;
	logic        p_run [4];
	logic [31:0] p_left [4];
	logic [31:0] p_target [4];
	logic [31:0] p_interval [4];
	logic [7:0]  p_mode [4];
	logic        p_high [4];
	logic [31:0] p_edge [4];
	logic        p_dir [4];
	logic        p_en [4];

	event_t  pending_events [$];
	result_t expected_results [$];
	int      errors = 0;
	int      accepted_events = 0;
	int      stall_hold = 0;
	bit      feed_done = 0;
	bit      bulk_stall_req = 0;

	task automatic reset_predictor();
		p_min_pulse = MIN_PULSE_RST;
		p_timeout = TIMEOUT_RST;
		p_divider = 8'd1;
		p_now = '0;
		p_rx_cnt = 0;
		p_rx_last = '0;
		p_tx = '0;
		p_led = 1'b0;
		for (int m = 0; m < 4; m++) begin
			p_run[m] = 0; p_left[m] = 0; p_target[m] = 0;
			p_interval[m] = INTERVAL_RST; p_mode[m] = 8'd1;
			p_high[m] = 0; p_edge[m] = 0; p_dir[m] = 1; p_en[m] = 0;
		end
	endtask

	function automatic logic [7:0] decode_frame();
		logic [7:0] code;
		logic [31:0] data;
		logic b1;
		int m;
		motor_op_t op;
		code = p_rx[0];
		data = {p_rx[4], p_rx[3], p_rx[2], p_rx[1]};
		b1 = p_rx[1] != 0;
		if (code > CODE_DIVIDER) return CODE_BAD_CMD;
		if (code == CODE_DIVIDER) begin
			p_tx = {24'd0, p_divider};
			return code;
		end
		if (code >= CODE_USTEP_WR) begin
			if (code[0]) return CODE_BAD_CMD;
			p_tx[7:0] = 8'd0;
			return code;
		end
		if (code >= CODE_USTEP_RD) begin
			p_tx[7:0] = 8'd0;
			return code;
		end
		m = code / 14;
		op = motor_op_t'(code % 14);
		case (op)
			OP_RD_RUN: begin p_tx[7:0] = {7'd0, p_run[m]}; return code; end
			OP_WR_RUN: begin
				if (p_run[m] != b1) begin
					p_run[m] = b1;
					if (b1) begin
						p_high[m] = 0;
						p_edge[m] = p_now - p_interval[m];
					end
				end
				return CODE_ACK;
			end
			OP_RD_STEPS: begin p_tx = p_left[m]; return code; end
			OP_WR_STEPS: begin p_left[m] = data; p_target[m] = data; return CODE_ACK; end
			OP_RD_TARGET: begin p_tx = p_target[m]; return code; end
			OP_WR_TARGET: begin p_target[m] = data; return CODE_ACK; end
			OP_RD_INTERVAL: begin p_tx = p_interval[m]; return code; end
			OP_WR_INTERVAL: begin p_interval[m] = data; return CODE_ACK; end
			OP_RD_MODE: begin p_tx[7:0] = p_mode[m]; return code; end
			OP_WR_MODE: begin p_mode[m] = p_rx[1]; return CODE_ACK; end
			OP_RD_DIR: begin p_tx[7:0] = {7'd0, p_dir[m]}; return code; end
			OP_WR_DIR: begin p_dir[m] = b1; return CODE_ACK; end
			OP_RD_EN: begin p_tx[7:0] = {7'd0, ~p_en[m]}; return code; end
			default: begin p_en[m] = ~b1; return CODE_ACK; end
		endcase
	endfunction

	function automatic bit advance_motor(int m);
		logic [31:0] delta;
		if (!p_run[m]) return 0;
		delta = p_now - p_edge[m];
		if (p_left[m] != 0) begin
			if (p_high[m]) begin
				if (delta >= p_min_pulse) p_high[m] = 0;
			end else if (delta >= p_interval[m]) begin
				p_high[m] = 1;
				p_left[m] = p_left[m] - p_mode[m];
				p_edge[m] = p_now;
			end
		end else if (p_high[m]) begin
			if (delta >= p_min_pulse) p_high[m] = 0;
		end else begin
			p_run[m] = 0;
			return 1;
		end
		return 0;
	endfunction

	task automatic predict_event(event_t ev);
		logic [7:0] codes [$];
		logic [7:0] x;
		result_t r;
		if (ev.kind) begin
			p_now++;
			for (int m = 0; m < 4; m++)
				if (advance_motor(m)) codes.push_back(CODE_END_BASE + 8'(m));
			if (p_rx_cnt != 0 && (p_now - p_rx_last) > {8'd0, p_timeout}) p_rx_cnt = 0;
		end else begin
			p_rx[p_rx_cnt] = ev.rx_byte;
			p_rx_last = p_now;
			p_rx_cnt++;
			if (p_rx_cnt >= FRAME_BYTES) begin
				x = p_rx[0] ^ p_rx[1] ^ p_rx[2] ^ p_rx[3] ^ p_rx[4];
				p_rx_cnt = 0;
				if (x == p_rx[5]) codes.push_back(decode_frame());
				else begin
					p_led = 1;
					codes.push_back(CODE_BAD_CHECK);
				end
			end
		end
		r = '0;
		for (int m = 0; m < 4; m++) begin
			r.step_lines[m] = p_high[m];
			r.dir_lines[m] = p_dir[m];
			r.enable_lines[m] = p_en[m];
		end
		r.error_led = p_led;
		if (codes.size() == 0) begin
			r.last_of_run = 1;
			expected_results.push_back(r);
		end
		foreach (codes[k]) begin
			r.frame_valid = 1;
			r.frame_code = codes[k];
			r.frame_data = p_tx;
			r.frame_check = codes[k] ^ p_tx[7:0] ^ p_tx[15:8] ^ p_tx[23:16] ^ p_tx[31:24];
			r.last_of_run = (k == codes.size() - 1);
			expected_results.push_back(r);
		end
	endtask

	// driver
	int src_gap = 0;
	always @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			predict_event(evt.data);
			accepted_events++;
			void'(pending_events.pop_front());
			src_gap = $urandom_range(0, 4);
		end else if (!evt.valid && src_gap > 0) begin
			src_gap--;
		end
		if (pending_events.size() > (evt.valid && evt.ready ? 0 : 0) &&
		    (src_gap == 0 || (evt.valid && !evt.ready)) && pending_events.size() > 0) begin
			evt.valid <= 1'b1;
			evt.data <= pending_events[0];
		end else begin
			evt.valid <= 1'b0;
		end
	end

	// long sink hold-off, counted on its own
	always @(posedge clk) begin
		if (bulk_stall_req && stall_hold == 0) stall_hold <= 300;
		else if (stall_hold > 0) stall_hold <= stall_hold - 1;
	end

	// monitor and sink
	int sink_gap = 0;
	always @(posedge clk) begin
		if (res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, res.data);
				errors++;
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (res.data !== e) begin
					$display("%0t: mismatch expected %h actual %h", $realtime, e, res.data);
					$display("  code %0d/%0d data %h/%h step %h/%h dir %h/%h en %h/%h",
						e.frame_code, res.data.frame_code, e.frame_data, res.data.frame_data,
						e.step_lines, res.data.step_lines, e.dir_lines, res.data.dir_lines,
						e.enable_lines, res.data.enable_lines);
					errors++;
				end
			end
			sink_gap = $urandom_range(0, 4);
		end
		if (stall_hold > 0) begin
			res.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	task automatic push_frame(logic [7:0] code, logic [31:0] data, bit corrupt = 0);
		event_t ev;
		logic [7:0] x;
		x = code ^ data[7:0] ^ data[15:8] ^ data[23:16] ^ data[31:24];
		ev.kind = 0;
		ev.rx_byte = code; pending_events.push_back(ev);
		for (int i = 0; i < 4; i++) begin
			ev.rx_byte = data[8*i +: 8];
			pending_events.push_back(ev);
		end
		ev.rx_byte = corrupt ? ~x : x;
		pending_events.push_back(ev);
	endtask

	task automatic push_ticks(int n);
		event_t ev;
		ev.kind = 1; ev.rx_byte = $urandom();
		repeat (n) pending_events.push_back(ev);
	endtask

	task automatic drain();
		while (pending_events.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIN_PULSE: p_min_pulse = val[15:0];
			CFG_TIMEOUT: p_timeout = val;
			default: p_divider = val[7:0];
		endcase
	endtask

	// random phase: mostly well-formed frames against small motor timings
	task automatic random_phase(int n);
		int k;
		logic [7:0] code;
		logic [31:0] data;
		event_t ev;
		k = 0;
		while (k < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					code = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 68);
					data = $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 12);
					if (code % 14 == 7 && code < 56) data = $urandom_range(0, 10);
					push_frame(code, data, $urandom_range(0, 15) == 0);
					k += 6;
				end
				5: begin
					ev.kind = 0; ev.rx_byte = $urandom();
					pending_events.push_back(ev);
					k++;
				end
				default: begin
					push_ticks($urandom_range(1, 8));
					k += 4;
				end
			endcase
		end
	endtask

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		evt.valid = 1'b0;
		evt.data = '0;
		res.ready = 1'b0;
		reset_predictor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reads, writes, microstep, divider, bad codes, bad check
		push_frame(8'd0, 32'd0);
		push_frame(8'd2, 32'd0);
		push_frame(8'd6, 32'd0);
		push_frame(CODE_DIVIDER, 32'hFFFF_FFFF);
		push_frame(CODE_USTEP_RD, 32'd0);
		push_frame(CODE_USTEP_WR, 32'd0);
		push_frame(8'd61, 32'd0);
		push_frame(8'd69, 32'd0);
		push_frame(8'd255, 32'hFFFF_FFFF);
		push_frame(8'd12, 32'd0, 1);
		push_frame(8'd7, 32'd2);
		push_frame(8'd3, 32'd3);
		push_frame(8'd1, 32'd1);
		push_ticks(20);
		drain();

		write_reg(CFG_MIN_PULSE, 24'd0);
		write_reg(CFG_TIMEOUT, 24'd5);
		write_reg(CFG_DIVIDER, 24'd255);
		// all motors end on the same tick; step mode zero on motor 3 later
		for (int m = 0; m < 4; m++) begin
			push_frame(8'(14 * m + 7), 32'd1);
			push_frame(8'(14 * m + 3), 32'd2);
			push_frame(8'(14 * m + 13), 32'd0);
			push_frame(8'(14 * m + 11), 32'd0);
		end
		for (int m = 0; m < 4; m++) push_frame(8'(14 * m + 1), 32'd1);
		push_frame(CODE_DIVIDER, 32'd0);
		push_ticks(12);
		// partial frame dropped by timeout
		push_frame(8'd0, 32'd0);
		void'(pending_events.pop_back());
		push_ticks(8);
		push_frame(8'd50, 32'd0);
		push_frame(8'd51, 32'd0);
		push_frame(8'd45, 32'd0);
		push_frame(8'd43, 32'd1);
		push_frame(8'd43, 32'd1);
		push_ticks(6);
		// stall the sink while the source keeps offering
		bulk_stall_req = 1;
		repeat (3) @(posedge clk);
		bulk_stall_req = 0;
		drain();
		push_frame(8'd43, 32'd0);
		push_ticks(4);
		drain();

		write_reg(CFG_MIN_PULSE, 24'd65535);
		write_reg(CFG_TIMEOUT, 24'hFFFFFF);
		write_reg(CFG_DIVIDER, 24'd1);
		random_phase(20);
		drain();
		write_reg(CFG_MIN_PULSE, 24'd2);
		write_reg(CFG_TIMEOUT, 24'd0);
		random_phase(20);
		drain();
		write_reg(CFG_MIN_PULSE, 24'd1);
		write_reg(CFG_TIMEOUT, 24'd40);
		write_reg(CFG_DIVIDER, 24'd17);
		random_phase(20);
		drain();

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
